// ===== src/wwv_pkg.sv =====
// Shared constants, codes and the kernel weight table of the window id vote block.
package wwv_pkg;

  // Word and field widths.
  localparam int ID_W       = 64;
  localparam int WORD_W     = 32;
  localparam int KEY_W      = WORD_W + ID_W;
  localparam int COORD_W    = 8;
  localparam int STORE_AW   = 2 * COORD_W;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int WT_W       = 23;
  localparam int CAND_DEPTH = 81;
  localparam int CAND_AW    = 7;
  localparam int CAND_W     = KEY_W + WT_W;
  localparam int MAX_RADIUS = 4;
  localparam int FRAME_MAX  = 256;
  localparam int S_DATA_W   = 136;
  localparam int M_DATA_W   = 96;

  // Operation codes carried on the input tuser.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_QUERY = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_EMPTY  = 2'd2;

  // Gaussian weight for absolute offsets a and b, indexed by a*a+b*b.
  function automatic logic [WT_W-1:0] kernel_weight(input logic [2:0] a, input logic [2:0] b);
    logic [5:0] d;
    logic [WT_W-1:0] w;
    d = 6'({3'b000, a} * {3'b000, a}) + 6'({3'b000, b} * {3'b000, b});
    case (d)
      6'd0:    w = 23'd65536;
      6'd1:    w = 23'd26943;
      6'd2:    w = 23'd11076;
      6'd4:    w = 23'd1872;
      6'd5:    w = 23'd770;
      6'd8:    w = 23'd53;
      6'd9:    w = 23'd22;
      6'd10:   w = 23'd9;
      6'd13:   w = 23'd1;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== src/wwv_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module wwv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/weighted_window_id_vote.sv =====
// A write is stored while idle, a clear zeroes the pixel store entry by entry and a radius-0
// query reads the centre pixel. A windowed query steps over the window positions and then
// votes over the candidates; the single candidate memory port is searched one entry at a
// time, with a read step and then a compare step for each entry.
// One item is in work at a time; tready is low until the item is finished.
// Reset is asynchronous; after reset a clearing pass zeroes the whole pixel store, during
// which no word is accepted (configuration writes still are).
module weighted_window_id_vote (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // x_coord[15:0], y_coord[31:16], radius[35:32], id_value[99:36], cache_word_in[131:100]
  input  logic [wwv_pkg::S_DATA_W-1:0]  s_tdata,
  // operation[1:0]
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // hit_id[63:0], result_cache[78:64], data_index[83:79], node_slot[95:84]
  output logic [wwv_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wwv_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CLEAR  = 4'd1;
  localparam logic [3:0] ST_CENTRE = 4'd2;
  localparam logic [3:0] ST_WPOS   = 4'd3;
  localparam logic [3:0] ST_PWAIT  = 4'd4;
  localparam logic [3:0] ST_SRD    = 4'd5;
  localparam logic [3:0] ST_SCMP   = 4'd6;
  localparam logic [3:0] ST_MRD    = 4'd7;
  localparam logic [3:0] ST_MCMP   = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0]            state_q, state_d;
  logic [STORE_AW-1:0]   clr_q, clr_d;
  logic [COORD_W-1:0]    x_q, x_d, y_q, y_d;
  logic [2:0]            r_q, r_d;
  logic signed [3:0]     dx_q, dx_d, dy_q, dy_d;
  logic [WT_W-1:0]       wt_q, wt_d, best_wt_q, best_wt_d;
  logic [KEY_W-1:0]      key_q, key_d, best_key_q, best_key_d;
  logic [CAND_AW-1:0]    k_q, k_d, cnt_q, cnt_d;
  logic [ID_W-1:0]       res_hit_q, res_hit_d;
  logic [WORD_W-1:0]     res_word_q, res_word_d;
  logic                  out_valid_q;
  logic [M_DATA_W-1:0]   out_data_q;
  logic [8:0]            fw_q, fh_q;
  logic [WORD_W-1:0]     ecw_q;

  // Input fields.
  logic [1:0]            in_op;
  logic [15:0]           in_x, in_y;
  logic [3:0]            in_r;
  logic [ID_W-1:0]       in_id;
  logic [WORD_W-1:0]     in_word;
  assign in_op   = s_tuser;
  assign in_x    = s_tdata[15:0];
  assign in_y    = s_tdata[31:16];
  assign in_r    = s_tdata[35:32];
  assign in_id   = s_tdata[99:36];
  assign in_word = s_tdata[131:100];

  // Frame limits in use.
  logic [8:0] fw_used, fh_used;
  assign fw_used = (fw_q > 9'(FRAME_MAX)) ? 9'(FRAME_MAX) : fw_q;
  assign fh_used = (fh_q > 9'(FRAME_MAX)) ? 9'(FRAME_MAX) : fh_q;

  logic in_frame, accept;
  assign in_frame = (in_x < {7'b0, fw_used}) && (in_y < {7'b0, fh_used});
  assign s_tready = (state_q == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Configuration port.
  logic cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {23'b0, fw_q};
      REG_HEIGHT: prdata = {23'b0, fh_q};
      REG_EMPTY:  prdata = ecw_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= 9'(FRAME_MAX);
      fh_q  <= 9'(FRAME_MAX);
      ecw_q <= '0;
    end else if (cfg_we) begin
      if (paddr[3:2] == REG_WIDTH)  fw_q  <= pwdata[8:0];
      if (paddr[3:2] == REG_HEIGHT) fh_q  <= pwdata[8:0];
      if (paddr[3:2] == REG_EMPTY)  ecw_q <= pwdata;
    end
  end

  // Window position and weight of the current offset.
  logic signed [9:0] nx, ny;
  logic [2:0]        adx, ady;
  logic              win_inside, win_last, last_x;
  logic [WT_W-1:0]   cur_wt;
  assign nx  = $signed({2'b00, x_q}) + $signed({{6{dx_q[3]}}, dx_q});
  assign ny  = $signed({2'b00, y_q}) + $signed({{6{dy_q[3]}}, dy_q});
  assign adx = dx_q[3] ? 3'(-dx_q) : dx_q[2:0];
  assign ady = dy_q[3] ? 3'(-dy_q) : dy_q[2:0];
  assign cur_wt     = kernel_weight(adx, ady);
  assign win_inside = !nx[9] && !ny[9] && (nx[8:0] < fw_used) && (ny[8:0] < fh_used);
  assign last_x     = (dx_q == $signed({1'b0, r_q}));
  assign win_last   = last_x && (dy_q == $signed({1'b0, r_q}));

  // Memory ports.
  logic                 st_we;
  logic [STORE_AW-1:0]  st_waddr, st_raddr;
  logic [KEY_W-1:0]     st_wdata, st_rdata;
  logic                 cd_we;
  logic [CAND_AW-1:0]   cd_waddr, cd_raddr;
  logic [CAND_W-1:0]    cd_wdata, cd_rdata;
  logic [KEY_W-1:0]     rd_key;
  logic [WT_W-1:0]      rd_wt;
  logic                 better;
  logic [KEY_W-1:0]     sel_key;
  logic                 adv;
  assign rd_key = cd_rdata[CAND_W-1:WT_W];
  assign rd_wt  = cd_rdata[WT_W-1:0];
  assign better = (k_q == '0) || (rd_wt > best_wt_q) ||
                  ((rd_wt == best_wt_q) && (rd_key < best_key_q));
  assign sel_key = better ? rd_key : best_key_q;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    x_d        = x_q;
    y_d        = y_q;
    r_d        = r_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    wt_d       = wt_q;
    key_d      = key_q;
    k_d        = k_q;
    cnt_d      = cnt_q;
    best_wt_d  = best_wt_q;
    best_key_d = best_key_q;
    res_hit_d  = res_hit_q;
    res_word_d = res_word_q;
    st_we      = 1'b0;
    st_waddr   = {in_y[COORD_W-1:0], in_x[COORD_W-1:0]};
    st_wdata   = {in_word, in_id};
    st_raddr   = {ny[COORD_W-1:0], nx[COORD_W-1:0]};
    cd_we      = 1'b0;
    cd_waddr   = k_q;
    cd_wdata   = {key_q, rd_wt + wt_q};
    cd_raddr   = k_q;
    adv        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        st_raddr = {in_y[COORD_W-1:0], in_x[COORD_W-1:0]};
        if (accept) begin
          x_d = in_x[COORD_W-1:0];
          y_d = in_y[COORD_W-1:0];
          case (in_op)
            OP_WRITE: st_we = in_frame;
            OP_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            OP_QUERY: begin
              if (!in_frame) begin
                res_hit_d  = '0;
                res_word_d = ecw_q;
                state_d    = ST_DONE;
              end else if (in_r == 4'd0) begin
                state_d = ST_CENTRE;
              end else begin
                r_d     = (in_r > 4'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : in_r[2:0];
                dx_d    = -$signed({1'b0, r_d});
                dy_d    = -$signed({1'b0, r_d});
                cnt_d   = '0;
                state_d = ST_WPOS;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_CENTRE: begin
        res_hit_d  = st_rdata[ID_W-1:0];
        res_word_d = st_rdata[KEY_W-1:ID_W];
        state_d    = ST_DONE;
      end
      ST_WPOS: begin
        // Read the pixel only if it lies in the frame and carries weight.
        if (win_inside && (cur_wt != '0)) begin
          wt_d    = cur_wt;
          state_d = ST_PWAIT;
        end else begin
          adv = 1'b1;
        end
      end
      ST_PWAIT: begin
        key_d = st_rdata;
        if (st_rdata[ID_W-1:0] == '0) begin
          adv = 1'b1;
        end else if (cnt_q == '0) begin
          cd_we    = 1'b1;
          cd_waddr = cnt_q;
          cd_wdata = {st_rdata, wt_q};
          cnt_d    = cnt_q + 1'b1;
          adv      = 1'b1;
        end else begin
          k_d     = '0;
          state_d = ST_SRD;
        end
      end
      ST_SRD: state_d = ST_SCMP;
      ST_SCMP: begin
        // Merge into a matching candidate, or append after the last one.
        if (rd_key == key_q) begin
          cd_we = 1'b1;
          adv   = 1'b1;
        end else if (k_q + 1'b1 == cnt_q) begin
          cd_we    = 1'b1;
          cd_waddr = cnt_q;
          cd_wdata = {key_q, wt_q};
          cnt_d    = cnt_q + 1'b1;
          adv      = 1'b1;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_SRD;
        end
      end
      ST_MRD: state_d = ST_MCMP;
      ST_MCMP: begin
        if (better) begin
          best_wt_d  = rd_wt;
          best_key_d = rd_key;
        end
        if (k_q + 1'b1 == cnt_q) begin
          res_hit_d  = sel_key[ID_W-1:0];
          res_word_d = sel_key[KEY_W-1:ID_W];
          state_d    = ST_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_MRD;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    // Step to the next window offset, or at the end on to the vote or the empty result.
    if (adv) begin
      if (win_last) begin
        k_d = '0;
        if (cnt_d == '0) begin
          res_hit_d  = '0;
          res_word_d = ecw_q;
          state_d    = ST_DONE;
        end else begin
          state_d = ST_MRD;
        end
      end else begin
        state_d = ST_WPOS;
        if (last_x) begin
          dx_d = -$signed({1'b0, r_q});
          dy_d = dy_q + 4'sd1;
        end else begin
          dx_d = dx_q + 4'sd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    r_q        <= r_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    wt_q       <= wt_d;
    key_q      <= key_d;
    best_wt_q  <= best_wt_d;
    best_key_q <= best_key_d;
    res_hit_q  <= res_hit_d;
    res_word_q <= res_word_d;
  end

  // Output register.
  logic load_out;
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || m_tready);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= {res_word_q[11:0], res_word_q[16:12], res_word_q[31:17], res_hit_q};
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = out_data_q;

  // Pixel store and candidate table.
  wwv_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH), .AW(STORE_AW)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  wwv_ram #(.WIDTH(CAND_W), .DEPTH(CAND_DEPTH), .AW(CAND_AW)) u_cand (
    .clk_i   (clk_i),
    .we_i    (cd_we),
    .waddr_i (cd_waddr),
    .wdata_i (cd_wdata),
    .raddr_i (cd_raddr),
    .rdata_o (cd_rdata)
  );

`ifndef SYNTHESIS
  a_cand_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(CAND_DEPTH))
    else $error("candidate count beyond table depth");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result word raised outside the done step");

  a_no_store_write_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && state_q != ST_CLEAR) |-> !st_we)
    else $error("pixel store written during a query");
`endif

endmodule

// ===== bench/weighted_window_id_vote_tb.sv =====
// Self-checking testbench of the window id vote block: directed table, then random phases.
module weighted_window_id_vote_tb;
  import wwv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [11:0] node_idx;
    logic [4:0]  data_idx;
    logic [14:0] cache;
    logic [63:0] hit;
  } vote_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  r;
    logic [63:0] id;
    logic [31:0] word;
    bit          typed;
    logic [63:0] exp_id;
    logic [31:0] exp_word;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_tvalid;
  logic         s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [3:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // Own copy of the pixel store and registers.
  logic [63:0]  mdl_id [STORE_DEPTH];
  logic [31:0]  mdl_word [STORE_DEPTH];
  logic [8:0]   cfg_width;
  logic [8:0]   cfg_height;
  logic [31:0]  cfg_empty;

  vote_t        pending_votes[$];
  int           mismatches;
  int           failures;
  int           votes_seen;
  int           hold_left;
  bit           no_idle;
  bit           hold_done;
  int           clears_sent;
  int           queries_sent;

  weighted_window_id_vote u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Overall time limit.
  initial begin
    #40ms;
    $display("Run timed out with %0d votes still pending", pending_votes.size());
    $display("TB_ERROR");
    $finish;
  end

  // One-dimensional Gaussian factor, scaled by 2^31.
  function automatic logic [63:0] gauss_factor(input int k);
    case (k)
      0:       return 64'd2147483648;
      1:       return 64'd882856921;
      2:       return 64'd61343946;
      3:       return 64'd720401;
      4:       return 64'd1430;
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic [63:0] pair_weight(input int a, input int b);
    logic [63:0] p;
    p = gauss_factor(a) * gauss_factor(b);
    return (p + (64'd1 << 45)) >> 46;
  endfunction

  function automatic vote_t split_word(input logic [63:0] id, input logic [31:0] w);
    vote_t v;
    v.hit      = id;
    v.cache    = w[31:17];
    v.data_idx = w[16:12];
    v.node_idx = w[11:0];
    return v;
  endfunction

  // Weighted vote over the window around (x,y).
  function automatic vote_t predict_vote(input logic [15:0] x, input logic [15:0] y,
                                         input logic [3:0] r_in);
    int          w, h, r, nx, ny, k, n, best, idx;
    logic [63:0] c_id [81];
    logic [31:0] c_word [81];
    logic [63:0] c_sum [81];
    logic [63:0] wt;
    w = (cfg_width < 256) ? cfg_width : 256;
    h = (cfg_height < 256) ? cfg_height : 256;
    r = (r_in > MAX_RADIUS) ? MAX_RADIUS : r_in;
    n = 0;
    if (!(x < w && y < h)) return split_word('0, cfg_empty);
    if (r == 0) return split_word(mdl_id[y*256+x], mdl_word[y*256+x]);
    for (int dy = -r; dy <= r; dy++) begin
      for (int dx = -r; dx <= r; dx++) begin
        nx = x + dx;
        ny = y + dy;
        if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
        idx = ny * 256 + nx;
        if (mdl_id[idx] == 0) continue;
        wt = pair_weight(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
        if (wt == 0) continue;
        for (k = 0; k < n; k++)
          if (c_word[k] == mdl_word[idx] && c_id[k] == mdl_id[idx]) break;
        if (k < n) begin
          c_sum[k] += wt;
        end else begin
          c_word[n] = mdl_word[idx];
          c_id[n]   = mdl_id[idx];
          c_sum[n]  = wt;
          n++;
        end
      end
    end
    if (n == 0) return split_word('0, cfg_empty);
    best = 0;
    for (k = 1; k < n; k++)
      if (c_sum[k] > c_sum[best] || (c_sum[k] == c_sum[best] &&
          (c_word[k] < c_word[best] || (c_word[k] == c_word[best] && c_id[k] < c_id[best]))))
        best = k;
    return split_word(c_id[best], c_word[best]);
  endfunction

  // Register write over the configuration port, setup then access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_WIDTH:  cfg_width  = value[8:0];
      REG_HEIGHT: cfg_height = value[8:0];
      REG_EMPTY:  cfg_empty  = value;
      default:    ;
    endcase
  endtask

  // Wait until every vote has come back and the block takes words again.
  task automatic wait_idle();
    while (pending_votes.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
    while (!s_tready) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_frame(input logic [8:0] w, input logic [8:0] h, input logic [31:0] e);
    wait_idle();
    reg_write(REG_WIDTH, {23'd0, w});
    reg_write(REG_HEIGHT, {23'd0, h});
    reg_write(REG_EMPTY, e);
  endtask

  // Offer one word and update the predicted store once it is taken.
  task automatic send_word(input row_t rw);
    vote_t v;
    int    w, h;
    if (!no_idle && $urandom_range(99) < 7) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_tvalid = 1'b1;
    s_tuser  = rw.op;
    s_tdata  = '0;
    s_tdata[131:0] = {rw.word, rw.id, rw.r, rw.y, rw.x};
    do @(posedge clk_i); while (!s_tready);
    w = (cfg_width < 256) ? cfg_width : 256;
    h = (cfg_height < 256) ? cfg_height : 256;
    case (rw.op)
      OP_WRITE: if (rw.x < w && rw.y < h) begin
        mdl_id[rw.y*256+rw.x]   = rw.id;
        mdl_word[rw.y*256+rw.x] = rw.word;
      end
      OP_CLEAR: begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
          mdl_id[i]   = '0;
          mdl_word[i] = '0;
        end
        clears_sent++;
      end
      OP_QUERY: begin
        v = rw.typed ? split_word(rw.exp_id, rw.exp_word) : predict_vote(rw.x, rw.y, rw.r);
        pending_votes.push_back(v);
        queries_sent++;
      end
      default: ;
    endcase
    @(negedge clk_i);
    s_tvalid = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off once results are flowing.
  initial begin
    m_tready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && votes_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = no_idle || ($urandom_range(99) >= 7);
      end
    end
  end

  // Result checker against the oldest pending vote.
  always @(posedge clk_i) begin
    vote_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata;
      votes_seen++;
      if (pending_votes.size() == 0) begin
        failures++;
        if (mismatches < 10) $display("Unexpected result word %h", got);
        mismatches++;
      end else begin
        want = pending_votes.pop_front();
        if (got.hit !== want.hit || got.cache !== want.cache ||
            got.data_idx !== want.data_idx || got.node_idx !== want.node_idx) begin
          failures++;
          if (mismatches < 10)
            $display("Vote mismatch: id %h/%h cache %h/%h data %h/%h node %h/%h (exp/got)",
                     want.hit, got.hit, want.cache, got.cache,
                     want.data_idx, got.data_idx, want.node_idx, got.node_idx);
          mismatches++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    row_t        rows[$];
    row_t        rw;
    logic [63:0] id_pool [4];
    logic [31:0] word_pool [4];
    logic [8:0]  ph_w [5];
    logic [8:0]  ph_h [5];
    int          uw, uh, sel;

    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_WRITE;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    mismatches = 0;
    failures = 0;
    votes_seen = 0;
    no_idle = 1'b0;
    clears_sent = 0;
    queries_sent = 0;
    cfg_width = 9'd256;
    cfg_height = 9'd256;
    cfg_empty = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      mdl_id[i]   = '0;
      mdl_word[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: op, x, y, radius, id, word, typed, expected id, expected word.
    rows.push_back('{OP_QUERY, 0, 0, 0, 0, 0, 1, 0, 0});
    rows.push_back('{OP_QUERY, 255, 255, 4, 0, 0, 1, 0, 0});
    rows.push_back('{OP_QUERY, 256, 0, 2, 0, 0, 1, 0, 0});
    rows.push_back('{OP_QUERY, 16'hFFFF, 16'hFFFF, 15, 0, 0, 1, 0, 0});
    rows.push_back('{2'd3, 5, 5, 1, 64'h1, 32'h1, 0, 0, 0});
    rows.push_back('{OP_WRITE, 10, 10, 0, '1, '1, 0, 0, 0});
    rows.push_back('{OP_QUERY, 10, 10, 0, 0, 0, 1, '1, '1});
    rows.push_back('{OP_WRITE, 11, 10, 0, 5, 32'h12345678, 0, 0, 0});
    rows.push_back('{OP_WRITE, 9, 10, 0, 5, 32'h12345678, 0, 0, 0});
    rows.push_back('{OP_QUERY, 10, 10, 1, 0, 0, 0, 0, 0});
    rows.push_back('{OP_QUERY, 10, 10, 15, 0, 0, 0, 0, 0});
    // Equal sums: smaller cache word wins, then smaller id.
    rows.push_back('{OP_WRITE, 21, 20, 0, 9, 2, 0, 0, 0});
    rows.push_back('{OP_WRITE, 19, 20, 0, 4, 2, 0, 0, 0});
    rows.push_back('{OP_QUERY, 20, 20, 1, 0, 0, 0, 0, 0});
    rows.push_back('{OP_WRITE, 20, 21, 0, 1, 3, 0, 0, 0});
    rows.push_back('{OP_WRITE, 20, 19, 0, 8, 1, 0, 0, 0});
    rows.push_back('{OP_QUERY, 20, 20, 3, 0, 0, 0, 0, 0});
    // Write outside the frame is dropped; radius zero returns an empty id as stored.
    rows.push_back('{OP_WRITE, 300, 5, 0, 7, 7, 0, 0, 0});
    rows.push_back('{OP_WRITE, 30, 30, 0, 0, 32'hABCD, 0, 0, 0});
    rows.push_back('{OP_QUERY, 30, 30, 0, 0, 0, 1, 0, 32'hABCD});
    rows.push_back('{OP_WRITE, 0, 0, 0, 3, 32'h55, 0, 0, 0});
    rows.push_back('{OP_QUERY, 0, 0, 4, 0, 0, 0, 0, 0});
    rows.push_back('{OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0});
    rows.push_back('{OP_QUERY, 10, 10, 0, 0, 0, 1, 0, 0});
    foreach (rows[i]) send_word(rows[i]);

    // Random phases, each with its own frame setting.
    ph_w = '{9'd256, 9'd1, 9'd511, 9'd17, 9'd200};
    ph_h = '{9'd256, 9'd1, 9'd511, 9'd9, 9'd0};
    for (int ph = 0; ph < 5; ph++) begin
      set_frame(ph_w[ph], ph_h[ph], ph == 1 ? 32'hFFFFFFFF : $urandom());
      no_idle = (ph == 3);
      uw = (cfg_width < 256) ? cfg_width : 256;
      uh = (cfg_height < 256) ? cfg_height : 256;
      for (int i = 0; i < 4; i++) begin
        id_pool[i]   = {$urandom(), $urandom()};
        word_pool[i] = $urandom();
      end
      for (int n = 0; n < 300; n++) begin
        // Once per phase the sender waits for every pending vote.
        if (n == 150) while (pending_votes.size() != 0) @(negedge clk_i);
        sel = $urandom_range(999);
        rw.typed = 1'b0;
        rw.exp_id = '0;
        rw.exp_word = '0;
        if (sel < 2) rw.op = OP_CLEAR;
        else if (sel < 40) rw.op = 2'd3;
        else if (sel < 290) rw.op = OP_QUERY;
        else rw.op = OP_WRITE;
        if ($urandom_range(9) == 0) begin
          rw.x = $urandom();
          rw.y = $urandom();
        end else begin
          rw.x = $urandom_range(uw + 1, 0) % 36;
          rw.y = $urandom_range(uh + 1, 0) % 36;
        end
        sel = $urandom_range(9);
        rw.r = (sel < 2) ? 4'd0 : (sel < 8) ? 4'($urandom_range(2, 1)) : 4'($urandom_range(15, 3));
        rw.id = ($urandom_range(9) == 0) ? {$urandom(), $urandom()} :
                ($urandom_range(7) == 0) ? 64'd0 : id_pool[$urandom_range(3)];
        rw.word = ($urandom_range(9) == 0) ? $urandom() : word_pool[$urandom_range(3)];
        send_word(rw);
      end
    end

    // Drain and let the block settle.
    wait_idle();
    repeat (200) @(negedge clk_i);
    $display("Covered %0d queries and %0d clears over five frame settings,", queries_sent,
             clears_sent);
    $display("with one long output hold-off; %0d mismatches seen.", mismatches);
    if (failures == 0 && pending_votes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
